// ===== rtl/sbim_pkg.sv =====
// Shared constants, register codes, state and command types for the stereo
// block intensity meter. No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sbim_pkg;

    // Longest block in sample pairs. A block that reaches it ends on its own.
    localparam int MAX_BLOCK = 1024;

    localparam int SAMPLE_W = 8;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W    = $clog2((2**SAMPLE_W - 1) * MAX_BLOCK + 1);

    // Divider: one quotient bit per step. The mean always fits in a sample.
    localparam int STEP_W   = $clog2(SAMPLE_W);
    localparam int DIV_W    = CNT_W + SAMPLE_W;

    // Configuration port.
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;
    localparam logic [SAMPLE_W-1:0] NOISE_THRESHOLD_RESET = SAMPLE_W'(5);
    localparam logic [TIME_W-1:0]   HOLDOFF_US_RESET      = TIME_W'(20000);

    typedef enum logic [0:0] {
        REG_NOISE_THRESHOLD = 1'b0,
        REG_HOLDOFF_US      = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accum;      // take a sample pair into the block totals
        logic              div_first;  // first divide step, start from the sums
        logic              div_step;   // run one divide step
        logic [STEP_W-1:0] div_shift;  // weight of the quotient bit in this step
        logic              finish;     // close the block, report if due
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_end;  // the offered pair closes the block
        logic report;     // the closed block produces a result
        logic out_busy;   // the output register holds a beat that is not taken
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbim_ctrl.sv =====
// Controller of the intensity meter: sequences accumulate, divide and decide.
// Depends on sbim_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sbim_ctrl
    import sbim_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.div_shift = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accum = 1'b1;
                    if (sts.block_end)
                    begin
                        state_next = ST_DIV;
                        step_next  = STEP_W'(SAMPLE_W - 1);
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == STEP_W'(SAMPLE_W - 1));
                if (step_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DECIDE:
            begin
                // If the block reports, hold the decision while an earlier result waits in the output register.
                if (!(sts.report && sts.out_busy))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sbim_datapath.sv =====
// Datapath of the intensity meter: block totals, bit-serial mean divider,
// noise gate, holdoff timer and output register. Depends on sbim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbim_datapath
    import sbim_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [SAMPLE_W-1:0] left_sample,
    input  wire logic [SAMPLE_W-1:0] right_sample,
    input  wire logic                last_in_block,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic [SAMPLE_W-1:0] noise_threshold,
    input  wire logic [TIME_W-1:0]   holdoff_us,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      left_level,
    output logic [SAMPLE_W-1:0]      right_level
);

    logic [SAMPLE_W-1:0] min_l_reg, min_l_next, max_l_reg, max_l_next;
    logic [SAMPLE_W-1:0] min_r_reg, min_r_next, max_r_reg, max_r_next;
    logic [SUM_W-1:0]    sum_l_reg, sum_l_next, sum_r_reg, sum_r_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SUM_W-1:0]    rem_l_reg, rem_l_next, rem_r_reg, rem_r_next;
    logic [SAMPLE_W-1:0] mean_l_reg, mean_l_next, mean_r_reg, mean_r_next;
    logic [SAMPLE_W-1:0] rep_l_reg, rep_l_next, rep_r_reg, rep_r_next;
    logic [TIME_W-1:0]   rep_time_reg, rep_time_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_l_reg, out_l_next, out_r_reg, out_r_next;

    logic [SUM_W-1:0]    rem_l_in, rem_r_in;
    logic [DIV_W-1:0]    trial;
    logic [DIV_W-1:0]    diff_l, diff_r;
    logic                ge_l, ge_r;
    logic                gate_l, gate_r;
    logic [SAMPLE_W-1:0] int_l, int_r;
    logic [TIME_W-1:0]   elapsed;
    logic                changed, holdoff_passed;

    // Divide step: compare the partial remainder with count times the bit weight.
    always_comb
    begin
        rem_l_in = cmd.div_first ? sum_l_reg : rem_l_reg;
        rem_r_in = cmd.div_first ? sum_r_reg : rem_r_reg;
        trial    = DIV_W'(count_reg) << cmd.div_shift;
        ge_l     = DIV_W'(rem_l_in) >= trial;
        ge_r     = DIV_W'(rem_r_in) >= trial;
        diff_l   = DIV_W'(rem_l_in) - trial;
        diff_r   = DIV_W'(rem_r_in) - trial;
    end

    // Noise gate and peak-to-peak. The mean lies between minimum and maximum.
    always_comb
    begin
        gate_l = ((mean_l_reg - min_l_reg) < noise_threshold)
              && ((max_l_reg - mean_l_reg) < noise_threshold);
        gate_r = ((mean_r_reg - min_r_reg) < noise_threshold)
              && ((max_r_reg - mean_r_reg) < noise_threshold);
        int_l  = gate_l ? '0 : (max_l_reg - min_l_reg);
        int_r  = gate_r ? '0 : (max_r_reg - min_r_reg);
    end

    // Report decision with wrapping elapsed time.
    always_comb
    begin
        elapsed        = time_reg - rep_time_reg;
        holdoff_passed = elapsed > holdoff_us;
        changed        = (int_l != rep_l_reg) || (int_r != rep_r_reg);
    end

    always_comb
    begin
        sts.block_end = last_in_block || (count_reg + CNT_W'(1) == CNT_W'(MAX_BLOCK));
        sts.report    = holdoff_passed && changed;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    // Next values of the block totals, divider and report state.
    always_comb
    begin
        min_l_next     = min_l_reg;
        max_l_next     = max_l_reg;
        min_r_next     = min_r_reg;
        max_r_next     = max_r_reg;
        sum_l_next     = sum_l_reg;
        sum_r_next     = sum_r_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        rem_l_next     = rem_l_reg;
        rem_r_next     = rem_r_reg;
        mean_l_next    = mean_l_reg;
        mean_r_next    = mean_r_reg;
        rep_l_next     = rep_l_reg;
        rep_r_next     = rep_r_reg;
        rep_time_next  = rep_time_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.accum)
        begin
            min_l_next = (left_sample < min_l_reg) ? left_sample : min_l_reg;
            max_l_next = (left_sample > max_l_reg) ? left_sample : max_l_reg;
            min_r_next = (right_sample < min_r_reg) ? right_sample : min_r_reg;
            max_r_next = (right_sample > max_r_reg) ? right_sample : max_r_reg;
            sum_l_next = sum_l_reg + SUM_W'(left_sample);
            sum_r_next = sum_r_reg + SUM_W'(right_sample);
            count_next = count_reg + CNT_W'(1);
            time_next  = time_us;
        end

        if (cmd.div_step)
        begin
            rem_l_next  = ge_l ? diff_l[SUM_W-1:0] : rem_l_in;
            rem_r_next  = ge_r ? diff_r[SUM_W-1:0] : rem_r_in;
            mean_l_next = {mean_l_reg[SAMPLE_W-2:0], ge_l};
            mean_r_next = {mean_r_reg[SAMPLE_W-2:0], ge_r};
        end

        if (cmd.finish)
        begin
            min_l_next = '1;
            max_l_next = '0;
            min_r_next = '1;
            max_r_next = '0;
            sum_l_next = '0;
            sum_r_next = '0;
            count_next = '0;
            if (sts.report)
            begin
                rep_l_next     = int_l;
                rep_r_next     = int_r;
                rep_time_next  = time_reg;
                out_l_next     = int_l;
                out_r_next     = int_r;
                out_valid_next = 1'b1;
            end
        end
    end

    // State with defined reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_l_reg     <= '1;
            max_l_reg     <= '0;
            min_r_reg     <= '1;
            max_r_reg     <= '0;
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            count_reg     <= '0;
            rep_l_reg     <= '0;
            rep_r_reg     <= '0;
            rep_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_l_reg     <= min_l_next;
            max_l_reg     <= max_l_next;
            min_r_reg     <= min_r_next;
            max_r_reg     <= max_r_next;
            sum_l_reg     <= sum_l_next;
            sum_r_reg     <= sum_r_next;
            count_reg     <= count_next;
            rep_l_reg     <= rep_l_next;
            rep_r_reg     <= rep_r_next;
            rep_time_reg  <= rep_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        rem_l_reg  <= rem_l_next;
        rem_r_reg  <= rem_r_next;
        mean_l_reg <= mean_l_next;
        mean_r_reg <= mean_r_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_level  = out_l_reg;
    assign right_level = out_r_reg;

endmodule

`default_nettype wire

// ===== rtl/stereo_block_intensity_meter_top.sv =====
// Top level of the stereo block intensity meter: stream ports, register port,
// controller and datapath. Depends on sbim_pkg, sbim_ctrl and sbim_datapath.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one stereo sample pair, tlast closes the block
//   m_axis    out        left and right intensity of a reported block
//   APB       in/out     noise_threshold at 0x0, holdoff_us at 0x4
//
// Pairs inside a block are taken back to back.
// A pair that closes a block passes through the accept, 8 divide steps
// (one mean bit per step for both channels) and a decide cycle.
// The decide cycle of a block that reports waits while an earlier result
// is not taken from m_axis.
// Reset clears the block totals, the reported values and the output beat.
`timescale 1ns / 1ps
`default_nettype none

module stereo_block_intensity_meter_top
    import sbim_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Sample stream.
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [47:0]        s_axis_tdata,  // left_sample, right_sample, time_us
    input  wire logic               s_axis_tlast,  // last_in_block
    // Result stream.
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [15:0]             m_axis_tdata,  // left_level, right_level
    // Register port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [SAMPLE_W-1:0] noise_thr_reg, noise_thr_next;
    logic [TIME_W-1:0]   holdoff_reg, holdoff_next;
    reg_idx_t            reg_idx;
    logic                wr_en;
    cmd_t                cmd;
    sts_t                sts;

    // Register file, written in the access phase.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        noise_thr_next = noise_thr_reg;
        holdoff_next   = holdoff_reg;
        prdata         = '0;
        unique case (reg_idx)
            REG_NOISE_THRESHOLD:
            begin
                prdata = PDATA_W'(noise_thr_reg);
                if (wr_en)
                begin
                    noise_thr_next = pwdata[SAMPLE_W-1:0];
                end
            end
            REG_HOLDOFF_US:
            begin
                prdata = PDATA_W'(holdoff_reg);
                if (wr_en)
                begin
                    holdoff_next = pwdata[TIME_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_thr_reg <= NOISE_THRESHOLD_RESET;
            holdoff_reg   <= HOLDOFF_US_RESET;
        end
        else
        begin
            noise_thr_reg <= noise_thr_next;
            holdoff_reg   <= holdoff_next;
        end
    end

    // Sequencing.
    sbim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and result register.
    sbim_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .left_sample     (s_axis_tdata[7:0]),
        .right_sample    (s_axis_tdata[15:8]),
        .last_in_block   (s_axis_tlast),
        .time_us         (s_axis_tdata[47:16]),
        .noise_threshold (noise_thr_reg),
        .holdoff_us      (holdoff_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .left_level      (m_axis_tdata[7:0]),
        .right_level     (m_axis_tdata[15:8])
    );

endmodule

`default_nettype wire

// ===== rtl/sbim_checker.sv =====
// Port-level checks for the stereo block intensity meter, bound to the top.
// Depends on sbim_pkg and stereo_block_intensity_meter_top.
`timescale 1ns / 1ps
`default_nettype none

module sbim_checker
    import sbim_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic               s_axis_tlast,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [15:0]        m_axis_tdata,
    input  wire logic               pready
);

    // A result beat that is stalled stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // A beat that closes a block starts the divide, so the input side closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted during block evaluation");

    // A new result only appears after a decide cycle with the input closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without block evaluation");

    // The register port never waits.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind stereo_block_intensity_meter_top sbim_checker u_sbim_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

`default_nettype wire
